// ----- rtl/core/stereo_peaking_eq_cascade_assert.svh -----
// Assertion macros used by the checker file of this block.
`ifndef STEREO_PEAKING_EQ_CASCADE_ASSERT_SVH
`define STEREO_PEAKING_EQ_CASCADE_ASSERT_SVH

// Checked on every edge outside reset.
`define SPEQ_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define SPEQ_CHECK_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/speq_pkg.sv -----
package speq_pkg;

  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 28;
  localparam int SIG_W    = 40;
  localparam int DIG_W    = 4;
  localparam int NCOEF    = 6;
  localparam int NZ       = 4;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [SIG_W-1:0]    sig_t;

  typedef struct packed {
    logic        command;
    sample_t     left_sample;
    sample_t     right_sample;
    logic [2:0]  band;
    logic        coef_channel;
    logic [2:0]  coef_index;
    coef_t       coef_value;
  } in_beat_t;

  typedef struct packed {
    sample_t left_out;
    sample_t right_out;
  } out_beat_t;

  localparam logic CMD_PROCESS = 1'b0;
  localparam logic CMD_LOAD    = 1'b1;

  typedef enum logic [2:0] {
    CI_B0, CI_B1, CI_B2, CI_A1, CI_A2, CI_GAIN
  } coef_idx_t;

  // Multiplications of one band section, in the order they run.
  typedef enum logic [2:0] {
    OP_B0, OP_A1, OP_A2, OP_B1, OP_B2, OP_GAIN
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RDZ, ST_V, ST_CRD, ST_CWT, ST_MUL, ST_WZ, ST_DONE
  } st_t;

  function automatic coef_idx_t op_coef(input op_t op);
    coef_idx_t c;
    case (op)
      OP_B0:   c = CI_B0;
      OP_A1:   c = CI_A1;
      OP_A2:   c = CI_A2;
      OP_B1:   c = CI_B1;
      OP_B2:   c = CI_B2;
      OP_GAIN: c = CI_GAIN;
      default: c = CI_B0;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/core/speq_ram.sv -----
module speq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/speq_mul.sv -----
module speq_mul #(
  parameter int FRAC = 22
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  speq_pkg::sig_t  a,
  input  speq_pkg::coef_t c,
  output logic            done,
  output speq_pkg::sig_t  p
);
  import speq_pkg::*;

  localparam int ACC_W = SIG_W + COEF_W;
  localparam int NDIG  = COEF_W / DIG_W;
  localparam int CNT_W = $clog2(NDIG + 1);
  localparam int EXT_W = (ACC_W > FRAC + SIG_W) ? ACC_W : FRAC + SIG_W;

  logic                    busy_r;
  logic [CNT_W-1:0]        cnt_r;
  sig_t                    a_r;
  coef_t                   c_r;
  logic signed [ACC_W-1:0] acc_r;
  logic                    done_r;
  sig_t                    p_r;

  logic signed [DIG_W:0]       dig;
  logic signed [SIG_W+DIG_W:0] pp;
  logic signed [ACC_W-1:0]     acc_nxt;
  logic signed [EXT_W:0]       rnd;
  logic [EXT_W-FRAC-SIG_W+1:0] hi;
  sig_t                        p_nxt;

  // Coefficient digits go most significant first; only the top one is signed.
  always_comb begin
    if (cnt_r == '0) begin
      dig = {c_r[COEF_W-1], c_r[COEF_W-1 -: DIG_W]};
    end else begin
      dig = {1'b0, c_r[COEF_W-1 -: DIG_W]};
    end
    pp      = a_r * dig;
    acc_nxt = (acc_r <<< DIG_W) + ACC_W'(pp);
  end

  // Round half up, drop the fraction and saturate.
  always_comb begin
    rnd = (EXT_W+1)'(acc_r) + ((EXT_W+1)'(1) <<< (FRAC - 1));
    hi  = rnd[EXT_W : FRAC+SIG_W-1];
    if ((&hi) || !(|hi)) begin
      p_nxt = rnd[FRAC+SIG_W-1 : FRAC];
    end else if (rnd[EXT_W]) begin
      p_nxt = {1'b1, {(SIG_W-1){1'b0}}};
    end else begin
      p_nxt = {1'b0, {(SIG_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(NDIG)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      c_r   <= c;
      acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r == CNT_W'(NDIG)) begin
        p_r <= p_nxt;
      end else begin
        acc_r <= acc_nxt;
        c_r   <= c_r <<< DIG_W;
      end
    end
  end

  assign done = done_r;
  assign p    = p_r;

endmodule

// ----- rtl/core/stereo_peaking_eq_cascade.sv -----
// A sample beat runs every band in use, left then right, through the 4-bit
// serial multiplier: six products per band and channel, each after a
// coefficient read (ST_CRD, ST_CWT); with zero bands it goes straight to
// ST_DONE. Load beats are written when taken. One sample beat at a time.
// Reset (rst_n low, synchronous) clears active_bands, all coefficients and all
// delay terms (through valid bits) and empties the result register.
module stereo_peaking_eq_cascade #(
  parameter int MAX_BANDS      = 8,
  parameter int COEF_FRAC_BITS = 22
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  speq_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output speq_pkg::out_beat_t out_data,
  input  logic                cfg_wr_en,
  input  logic [3:0]          cfg_wr_data
);
  import speq_pkg::*;

  // Coefficients and delay terms live in two single-port-read RAMs, one row
  // group per band and channel. Valid bits stand in for the reset clear.
  localparam int CDEPTH = MAX_BANDS * 2 * NCOEF;
  localparam int ZDEPTH = MAX_BANDS * 2 * NZ;
  localparam int CA_W   = $clog2(CDEPTH);
  localparam int ZA_W   = $clog2(ZDEPTH);
  localparam int BC_W   = $clog2(MAX_BANDS + 1);

  st_t              state_r, state_nxt;
  logic [3:0]       active_r;
  logic [BC_W-1:0]  band_r, nb_r;
  logic             ch_r;
  logic [2:0]       cnt_r;
  op_t              op_r;
  sig_t             xl_r, xr_r, v_r, t_r, d_r;
  sig_t             z_r [NZ];
  logic             out_valid_r;
  out_beat_t        out_data_r;
  logic [CDEPTH-1:0] cvalid_r;
  logic [ZDEPTH-1:0] zvalid_r;
  logic             crv_r, zrv_r;

  sig_t             x_cur;
  logic [BC_W-1:0]  n_bands;
  logic             take_proc, take_load, load_ok, out_take, last_pass;
  logic [CA_W-1:0]  c_waddr, c_raddr;
  logic [ZA_W-1:0]  z_addr;
  coef_t            c_rdata;
  logic [SIG_W-1:0] z_rdata;
  logic             c_we, z_we, mul_start, mul_done;
  sig_t             mul_a, mul_p;
  coef_t            mul_c;

  function automatic sig_t sat_add(input sig_t a, input sig_t b, input logic sub);
    logic signed [SIG_W:0] s;
    s = sub ? ((SIG_W+1)'(a) - (SIG_W+1)'(b)) : ((SIG_W+1)'(a) + (SIG_W+1)'(b));
    if (s[SIG_W] != s[SIG_W-1]) begin
      return s[SIG_W] ? {1'b1, {(SIG_W-1){1'b0}}} : {1'b0, {(SIG_W-1){1'b1}}};
    end
    return s[SIG_W-1:0];
  endfunction

  function automatic sample_t sat_out(input sig_t x);
    logic [SIG_W-SAMPLE_W:0] hi;
    hi = x[SIG_W-1:SAMPLE_W-1];
    if ((&hi) || !(|hi)) begin
      return x[SAMPLE_W-1:0];
    end
    return x[SIG_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
  endfunction

  assign x_cur     = ch_r ? xr_r : xl_r;
  assign n_bands   = (int'(active_r) > MAX_BANDS) ? BC_W'(MAX_BANDS) : BC_W'(active_r);
  assign take_proc = (state_r == ST_IDLE) && in_valid && (in_data.command == CMD_PROCESS);
  assign take_load = (state_r == ST_IDLE) && in_valid && (in_data.command == CMD_LOAD);
  assign load_ok   = (int'(in_data.band) < MAX_BANDS) && (int'(in_data.coef_index) < NCOEF);
  assign out_take  = !out_valid_r || !out_stall;
  assign last_pass = ch_r && (band_r + 1'b1 == nb_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (take_proc) begin
          state_nxt = (n_bands == '0) ? ST_DONE : ST_RDZ;
        end
      end
      ST_RDZ: begin
        if (cnt_r == 3'(NZ)) begin
          state_nxt = ST_V;
        end
      end
      ST_V:   state_nxt = ST_CRD;
      ST_CRD: state_nxt = ST_CWT;
      ST_CWT: state_nxt = ST_MUL;
      ST_MUL: begin
        if (mul_done) begin
          state_nxt = (op_r == OP_GAIN) ? ST_WZ : ST_CRD;
        end
      end
      ST_WZ: begin
        if (cnt_r == 3'(NZ - 1)) begin
          state_nxt = last_pass ? ST_DONE : ST_RDZ;
        end
      end
      ST_DONE: begin
        if (out_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake, RAM ports and multiplier launch.
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    c_we      = take_load && load_ok;
    c_waddr   = CA_W'((int'(in_data.band) * 2 + int'(in_data.coef_channel)) * NCOEF
                      + int'(in_data.coef_index));
    c_raddr   = CA_W'((int'(band_r) * 2 + int'(ch_r)) * NCOEF + int'(op_coef(op_r)));
    z_addr    = ZA_W'((int'(band_r) * 2 + int'(ch_r)) * NZ + int'(cnt_r[1:0]));
    z_we      = (state_r == ST_WZ);
    mul_start = (state_r == ST_CWT);
    mul_a     = (op_r == OP_GAIN) ? d_r : v_r;
    mul_c     = crv_r ? c_rdata : '0;
  end

  speq_ram #(.WIDTH(COEF_W), .DEPTH(CDEPTH)) u_coef_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (in_data.coef_value),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  speq_ram #(.WIDTH(SIG_W), .DEPTH(ZDEPTH)) u_delay_ram (
    .clk   (clk),
    .we    (z_we),
    .waddr (z_addr),
    .wdata (z_r[cnt_r[1:0]]),
    .raddr (z_addr),
    .rdata (z_rdata)
  );

  speq_mul #(.FRAC(COEF_FRAC_BITS)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .c     (mul_c),
    .done  (mul_done),
    .p     (mul_p)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= '0;
      cnt_r       <= '0;
      op_r        <= OP_B0;
      out_valid_r <= 1'b0;
      cvalid_r    <= '0;
      zvalid_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        active_r <= cfg_wr_data;
      end
      if (c_we) begin
        cvalid_r[c_waddr] <= 1'b1;
      end
      if (z_we) begin
        zvalid_r[z_addr] <= 1'b1;
      end
      case (state_r)
        ST_RDZ:  cnt_r <= (cnt_r == 3'(NZ)) ? 3'd0 : cnt_r + 3'd1;
        ST_WZ:   cnt_r <= (cnt_r == 3'(NZ - 1)) ? 3'd0 : cnt_r + 3'd1;
        default: cnt_r <= 3'd0;
      endcase
      if (state_r == ST_MUL && mul_done) begin
        op_r <= (op_r == OP_GAIN) ? OP_B0 : op_t'(op_r + 3'd1);
      end
      // A finished beat enters the result register as soon as it is free.
      if (state_r == ST_DONE && out_take) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    crv_r <= cvalid_r[c_raddr];
    zrv_r <= zvalid_r[z_addr];
    if (take_proc) begin
      xl_r   <= sig_t'(in_data.left_sample);
      xr_r   <= sig_t'(in_data.right_sample);
      band_r <= '0;
      ch_r   <= 1'b0;
      nb_r   <= n_bands;
    end
    if (state_r == ST_RDZ && cnt_r != 3'd0) begin
      z_r[2'(cnt_r - 3'd1)] <= zrv_r ? sig_t'(z_rdata) : '0;
    end
    if (state_r == ST_V) begin
      v_r <= sat_add(z_r[0], x_cur, 1'b0);
    end
    // Each product is folded in as it lands; delay terms are updated in place
    // because every old term is read before its slot is overwritten.
    if (state_r == ST_MUL && mul_done) begin
      case (op_r)
        OP_B0: t_r <= sat_add(mul_p, z_r[2], 1'b0);
        OP_A1: z_r[0] <= sat_add(mul_p, z_r[1], 1'b0);
        OP_A2: z_r[1] <= mul_p;
        OP_B1: z_r[2] <= sat_add(mul_p, z_r[3], 1'b0);
        OP_B2: begin
          z_r[3] <= mul_p;
          d_r    <= sat_add(x_cur, t_r, 1'b1);
        end
        OP_GAIN: begin
          if (ch_r) begin
            xr_r <= sat_add(x_cur, mul_p, 1'b0);
          end else begin
            xl_r <= sat_add(x_cur, mul_p, 1'b0);
          end
        end
        default: t_r <= t_r;
      endcase
    end
    if (state_r == ST_WZ && cnt_r == 3'(NZ - 1)) begin
      ch_r <= ~ch_r;
      if (ch_r) begin
        band_r <= band_r + 1'b1;
      end
    end
    if (state_r == ST_DONE && out_take) begin
      out_data_r.left_out  <= sat_out(xl_r);
      out_data_r.right_out <= sat_out(xr_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/core/speq_checker.sv -----
module speq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input speq_pkg::in_beat_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input speq_pkg::out_beat_t out_data
);
  import speq_pkg::*;
  `include "stereo_peaking_eq_cascade_assert.svh"

  `SPEQ_CHECK_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result beat right after reset")
  `SPEQ_CHECK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result beat dropped or changed")
  `SPEQ_CHECK(a_proc_busy, in_valid && !in_stall && (in_data.command == CMD_PROCESS) |=> in_stall, "sample beat did not occupy the block")
  `SPEQ_CHECK(a_load_quiet, in_valid && !in_stall && (in_data.command == CMD_LOAD) && !out_valid |=> !out_valid, "load beat produced a result")

endmodule

bind stereo_peaking_eq_cascade speq_checker u_speq_checker (.*);

// ----- bench/stereo_peaking_eq_cascade_tb.sv -----
`timescale 1ns / 1ps

module stereo_peaking_eq_cascade_tb;
  import speq_pkg::*;

  localparam int BANDS     = 8;
  localparam int FRAC      = 22;
  localparam int DRAIN_GAP = 20;
  localparam logic [2:0] IDX_SPARE_LO = 3'd6;
  localparam logic [2:0] IDX_SPARE_HI = 3'd7;
  localparam logic signed [71:0] SIG_MAX = (72'sd1 <<< (SIG_W - 1)) - 72'sd1;
  localparam logic signed [71:0] SIG_MIN = -(72'sd1 <<< (SIG_W - 1));
  localparam sample_t SMP_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
  localparam sample_t SMP_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};
  localparam coef_t COEF_MAX = {1'b0, {(COEF_W - 1){1'b1}}};
  localparam coef_t COEF_MIN = {1'b1, {(COEF_W - 1){1'b0}}};
  localparam coef_t COEF_ONE = coef_t'(1) <<< FRAC;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;
  logic      cfg_wr_en;
  logic [3:0] cfg_wr_data;

  stereo_peaking_eq_cascade DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shadow state of the equalizer: band count, coefficient bank and the
  // four delay terms of every band and channel.
  logic [3:0] eq_bands;
  coef_t      eq_coef [BANDS][2][NCOEF];
  sig_t       eq_delay [BANDS][2][NZ];

  // Equalized sample pairs still owed by the block, oldest first.
  out_beat_t  owed_pairs[$];

  int mismatches;
  int sender_idle_pct;
  int recv_stall_pct;
  int hold_request;

  function automatic sig_t clamp_sig(input logic signed [71:0] x);
    if (x > SIG_MAX) return sig_t'(SIG_MAX);
    if (x < SIG_MIN) return sig_t'(SIG_MIN);
    return sig_t'(x);
  endfunction

  function automatic sample_t clamp_sample(input sig_t x);
    if (x > sig_t'(SMP_MAX)) return SMP_MAX;
    if (x < sig_t'(SMP_MIN)) return SMP_MIN;
    return sample_t'(x);
  endfunction

  // Product of a signal and a Q5.22 coefficient, rounded half up. The 72-bit
  // intermediate holds the full product, so the arithmetic shift is a floor.
  function automatic sig_t scale(input sig_t v, input coef_t c);
    logic signed [71:0] p;
    p = v * c;
    p = p + (72'sd1 <<< (FRAC - 1));
    return clamp_sig(p >>> FRAC);
  endfunction

  // One peaking section followed by the dry/wet mix. The delay terms are
  // updated in place, exactly in the order the section defines.
  function automatic sig_t run_band(input int b, input int ch, input sig_t x);
    sig_t v;
    sig_t t;
    v = clamp_sig(eq_delay[b][ch][0] + x);
    t = clamp_sig(scale(v, eq_coef[b][ch][CI_B0]) + eq_delay[b][ch][2]);
    eq_delay[b][ch][0] = clamp_sig(scale(v, eq_coef[b][ch][CI_A1]) + eq_delay[b][ch][1]);
    eq_delay[b][ch][1] = scale(v, eq_coef[b][ch][CI_A2]);
    eq_delay[b][ch][2] = clamp_sig(scale(v, eq_coef[b][ch][CI_B1]) + eq_delay[b][ch][3]);
    eq_delay[b][ch][3] = scale(v, eq_coef[b][ch][CI_B2]);
    return clamp_sig(x + scale(clamp_sig(x - t), eq_coef[b][ch][CI_GAIN]));
  endfunction

  // Applies one accepted beat to the shadow state. Returns 1 with the
  // equalized pair for a sample beat, 0 for a coefficient load.
  function automatic bit equalize(input in_beat_t b, output out_beat_t res);
    int   n;
    sig_t l;
    sig_t r;
    res = '0;
    if (b.command == CMD_LOAD) begin
      // Spare coefficient slots are dropped; delay terms are left alone.
      if (b.coef_index < NCOEF)
        eq_coef[b.band][b.coef_channel][b.coef_index] = b.coef_value;
      return 1'b0;
    end
    // Band counts above the bank size act as the full bank.
    n = (eq_bands > BANDS) ? BANDS : eq_bands;
    l = sig_t'(b.left_sample);
    r = sig_t'(b.right_sample);
    for (int i = 0; i < n; i++) begin
      l = run_band(i, 0, l);
      r = run_band(i, 1, r);
    end
    res.left_out  = clamp_sample(l);
    res.right_out = clamp_sample(r);
    return 1'b1;
  endfunction

  function automatic in_beat_t sample_beat(input sample_t l, input sample_t r);
    in_beat_t b;
    b = in_beat_t'({$urandom, $urandom, $urandom});
    b.command      = CMD_PROCESS;
    b.left_sample  = l;
    b.right_sample = r;
    return b;
  endfunction

  function automatic in_beat_t coef_beat(input logic [2:0] band, input logic ch,
                                         input logic [2:0] idx, input coef_t val);
    in_beat_t b;
    b = in_beat_t'({$urandom, $urandom, $urandom});
    b.command      = CMD_LOAD;
    b.band         = band;
    b.coef_channel = ch;
    b.coef_index   = idx;
    b.coef_value   = val;
    return b;
  endfunction

  // Random coefficient load. Half of them are tame values near a real
  // peaking filter so that the cascade does not sit in saturation; the rest
  // use the whole field.
  function automatic in_beat_t random_coef_beat();
    logic [2:0] idx;
    coef_t      val;
    idx = 3'($urandom_range(7));
    if ($urandom_range(1)) begin
      val = coef_t'($urandom);
    end else begin
      case (idx)
        CI_B0:   val = COEF_ONE + coef_t'($signed($urandom_range(2 ** 20)) - (2 ** 19));
        CI_GAIN: val = coef_t'($signed($urandom_range(2 ** 23)) - (2 ** 22));
        default: val = coef_t'($signed($urandom_range(2 ** 20)) - (2 ** 19));
      endcase
    end
    return coef_beat(3'($urandom_range(7)), 1'($urandom_range(1)), idx, val);
  endfunction

  // Directed rows. Pass-through results with no bands in use are typed in.
  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t want;
  } row_t;

  row_t directed[$];

  function automatic row_t typed_row(input sample_t l, input sample_t r);
    row_t t;
    t.beat  = sample_beat(l, r);
    t.typed = 1'b1;
    t.want.left_out  = l;
    t.want.right_out = r;
    return t;
  endfunction

  function automatic row_t plain_row(input in_beat_t b);
    row_t t;
    t.beat  = b;
    t.typed = 1'b0;
    t.want  = '0;
    return t;
  endfunction

  // Drives one beat and holds it until the block takes it, then books the
  // expected pair. The valid line is only ever written at falling edges.
  task automatic offer(input in_beat_t b, input bit typed, input out_beat_t want);
    out_beat_t res;
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_data  <= in_beat_t'({$urandom, $urandom, $urandom});
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    if (equalize(b, res))
      owed_pairs.push_back(typed ? want : res);
  endtask

  task automatic quiet_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Waits for every owed pair, then lets a trailing load settle.
  task automatic drain();
    quiet_input();
    while (owed_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_bands(input logic [3:0] n);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= n;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    eq_bands = n;
  endtask

  // Receiver: random stalls, plus a long hold when one is requested. The
  // hold is counted here so the sender keeps pushing beats meanwhile.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Result checker: every pair the block hands over must match the oldest
  // owed pair field by field.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (owed_pairs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: left %0d right %0d",
                   out_data.left_out, out_data.right_out);
      end else begin
        if (out_data.left_out !== owed_pairs[0].left_out ||
            out_data.right_out !== owed_pairs[0].right_out) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected left %0d right %0d, got left %0d right %0d",
                     owed_pairs[0].left_out, owed_pairs[0].right_out,
                     out_data.left_out, out_data.right_out);
        end
        void'(owed_pairs.pop_front());
      end
    end
  end

  // Hard stop in case the block hangs; far beyond the slowest legal run.
  initial begin
    #60ms;
    $display("FAIL");
    $finish;
  end

  // Band count and beat count of each random phase. Large counts get few
  // beats since every sample then runs through the whole bank.
  int phase_bands [8] = '{1, 15, 0, 2, 8, 3, 4, 1};
  int phase_beats [8] = '{80, 20, 60, 80, 20, 70, 60, 110};

  initial begin
    out_beat_t none;
    none            = '0;
    mismatches      = 0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_request    = 0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    eq_bands    = '0;
    foreach (eq_coef[b, c, k]) eq_coef[b][c][k] = '0;
    foreach (eq_delay[b, c, k]) eq_delay[b][c][k] = '0;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, with no bands in use: pass-through at the sample
    // extremes, loads of every coefficient index including the two spare ones, and
    // coefficient extremes that the later phases then run through.
    directed.push_back(typed_row(SMP_MAX, SMP_MIN));
    directed.push_back(typed_row(SMP_MIN, SMP_MAX));
    directed.push_back(typed_row('0, '0));
    directed.push_back(typed_row(-sample_t'(1), sample_t'(1)));
    for (int k = 0; k < 8; k++)
      directed.push_back(plain_row(coef_beat(3'(k), k[0], 3'(k),
                                             k[1] ? COEF_MIN : COEF_MAX)));
    directed.push_back(plain_row(coef_beat(3'd0, 1'b0, IDX_SPARE_LO, COEF_MAX)));
    directed.push_back(plain_row(coef_beat(3'd7, 1'b1, IDX_SPARE_HI, COEF_MIN)));
    directed.push_back(plain_row(coef_beat(3'd0, 1'b0, CI_B0, COEF_ONE)));
    directed.push_back(plain_row(coef_beat(3'd0, 1'b1, CI_B0, COEF_ONE)));
    directed.push_back(plain_row(coef_beat(3'd0, 1'b0, CI_GAIN, COEF_ONE)));
    directed.push_back(plain_row(coef_beat(3'd0, 1'b1, CI_GAIN, -COEF_ONE)));
    directed.push_back(typed_row(SMP_MAX, SMP_MAX));
    directed.push_back(typed_row(SMP_MIN, SMP_MIN));
    foreach (directed[i])
      offer(directed[i].beat, directed[i].typed, directed[i].want);
    drain();

    for (int p = 0; p < 8; p++) begin
      write_bands(4'(phase_bands[p]));
      case (p % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin sender_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      // One phase starts behind a long receiver hold so the block backs up
      // and stalls its input while beats keep coming.
      if (p == 2) hold_request = 600;
      for (int i = 0; i < phase_beats[p]; i++) begin
        if ($urandom_range(99) < 30)
          offer(random_coef_beat(), 1'b0, none);
        else
          offer(sample_beat(sample_t'($urandom), sample_t'($urandom)), 1'b0, none);
      end
      drain();
    end

    if (mismatches == 0 && owed_pairs.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
